/* design/tlbf_pkg.sv */
// Package for the TLB translate unit: state encoding, status codes, command
// and status structs shared by controller and datapath. No dependencies.
package tlbf_pkg;

    localparam logic [1:0] ST_HIT    = 2'd0;
    localparam logic [1:0] ST_MISS   = 2'd1;
    localparam logic [1:0] ST_REFILL = 2'd2;

    localparam logic [1:0] CFG_PAGE_SIZE = 2'd0;
    localparam logic [1:0] CFG_ENTRIES   = 2'd1;
    localparam logic [1:0] CFG_MODE      = 2'd2;

    localparam logic OP_TRANSLATE = 1'b0;
    localparam logic OP_REFILL    = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_SCAN,
        S_WRITE,
        S_MUL,
        S_DONE
    } state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;       // capture input item
        logic div_step;   // one restoring division step
        logic scan_clr;   // restart scan pointer
        logic scan_step;  // inspect one entry
        logic write_ent;  // write refill victim
        logic mul;        // form physical address
        logic out_load;   // place result in output register
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic div_done;
        logic scan_done;
        logic is_refill;
        logic do_write;
    } stat_t;

endpackage

/* design/tlbf_ctrl.sv */
// Controller for the TLB translate unit: sequences division, scan, write,
// multiply and result hand-off. Depends on tlbf_pkg.
module tlbf_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic            out_busy,
    input  tlbf_pkg::stat_t st,
    output tlbf_pkg::cmd_t  cmd
);
    import tlbf_pkg::*;

    state_t state_reg, state_next;

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (in_valid) state_next = S_DIV;
            S_DIV:   if (st.div_done) state_next = S_SCAN;
            S_SCAN:  if (st.scan_done)
                         state_next = (st.is_refill && st.do_write) ? S_WRITE : S_MUL;
            S_WRITE: state_next = S_MUL;
            S_MUL:   state_next = S_DONE;
            S_DONE:  if (!out_busy) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cmd.scan_clr = st.div_done;
            end
            S_SCAN:  cmd.scan_step = !st.scan_done;
            S_WRITE: cmd.write_ent = 1'b1;
            S_MUL:   cmd.mul = 1'b1;
            S_DONE:  cmd.out_load = !out_busy;
            default: cmd = '0;
        endcase
    end
endmodule

/* design/tlbf_dp.sv */
// Datapath for the TLB translate unit: entry store, divider, scan,
// victim choice, stamps and address multiply. Depends on tlbf_pkg.
module tlbf_dp #(
    parameter int ENTRIES = 32
) (
    input  logic            clk,
    input  logic            rst_n,
    input  tlbf_pkg::cmd_t  cmd,
    output tlbf_pkg::stat_t st,
    input  logic            cfg_valid,
    input  logic [1:0]      cfg_index,
    input  logic [31:0]     cfg_data,
    input  logic            opcode,
    input  logic [15:0]     pid,
    input  logic [30:0]     logical_address,
    input  logic [15:0]     frame,
    output logic [1:0]      res_status,
    output logic [31:0]     res_phys,
    output logic [30:0]     res_page
);
    import tlbf_pkg::*;

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);

    // Configuration
    logic [16:0] page_size_reg;
    logic [5:0]  entries_reg;
    logic        mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_size_reg <= 17'd64;
            entries_reg   <= 6'd32;
            mode_reg      <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_PAGE_SIZE: page_size_reg <= cfg_data[16:0];
                CFG_ENTRIES:   entries_reg   <= cfg_data[5:0];
                CFG_MODE:      mode_reg      <= cfg_data[0];
                default:       ;
            endcase
        end
    end

    // Entry store
    logic              valid_reg [ENTRIES];
    logic [15:0]       epid_reg  [ENTRIES];
    logic [30:0]       epage_reg [ENTRIES];
    logic [15:0]       efrm_reg  [ENTRIES];
    logic [31:0]       eload_reg [ENTRIES];
    logic [31:0]       euse_reg  [ENTRIES];
    logic [31:0]       load_cnt_reg, use_cnt_reg;

    // Captured item
    logic        op_reg;
    logic [15:0] pid_reg;
    logic [15:0] frm_reg;
    logic [16:0] ps_reg;
    logic [CW-1:0] n_reg;

    // Divider
    logic [30:0] quo_reg;
    logic [16:0] rem_reg;
    logic [4:0]  dcnt_reg;
    logic [17:0] trial;

    // Scan
    logic [CW-1:0] sidx_reg;
    logic          hit_reg;
    logic [15:0]   hfrm_reg;
    logic          free_reg;
    logic [IW-1:0] slot_reg;
    logic [31:0]   best_reg;
    logic [IW-1:0] cur;
    logic          match;
    logic [31:0]   stamp;

    logic [31:0] prod_reg;

    assign trial = {rem_reg, quo_reg[30]} - {1'b0, ps_reg};
    assign cur   = sidx_reg[IW-1:0];
    assign match = valid_reg[cur] && epid_reg[cur] == pid_reg && epage_reg[cur] == quo_reg;
    assign stamp = mode_reg ? euse_reg[cur] : eload_reg[cur];

    assign st.div_done  = (dcnt_reg == 5'd30);
    assign st.scan_done = (sidx_reg >= n_reg);
    assign st.is_refill = op_reg;
    assign st.do_write  = (n_reg != '0);

    // Capture, divide, scan
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= opcode;
            pid_reg  <= pid;
            frm_reg  <= frame;
            ps_reg   <= (page_size_reg == '0) ? 17'd1 : page_size_reg;
            n_reg    <= ({26'd0, entries_reg} > 32'(ENTRIES)) ? CW'(ENTRIES)
                                                               : CW'(entries_reg);
            quo_reg  <= logical_address;
            rem_reg  <= '0;
            dcnt_reg <= '0;
        end
        if (cmd.div_step)
        begin
            dcnt_reg <= dcnt_reg + 5'd1;
            if (!trial[17])
            begin
                rem_reg <= trial[16:0];
                quo_reg <= {quo_reg[29:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[15:0], quo_reg[30]};
                quo_reg <= {quo_reg[29:0], 1'b0};
            end
        end
        if (cmd.scan_clr)
        begin
            sidx_reg <= '0;
            hit_reg  <= 1'b0;
            free_reg <= 1'b0;
            slot_reg <= '0;
        end
        if (cmd.scan_step)
        begin
            sidx_reg <= sidx_reg + CW'(1);
            if (!op_reg)
            begin
                if (match)
                begin
                    hit_reg  <= 1'b1;
                    hfrm_reg <= efrm_reg[cur];
                end
            end
            else if (!free_reg)
            begin
                if (!valid_reg[cur])
                begin
                    free_reg <= 1'b1;
                    slot_reg <= cur;
                end
                else if (sidx_reg == '0 || stamp < best_reg)
                begin
                    slot_reg <= cur;
                    best_reg <= stamp;
                end
            end
        end
        // Form physical address; remainder is the offset
        if (cmd.mul)
            prod_reg <= 32'((op_reg ? frm_reg : hfrm_reg) * ps_reg) + 32'(rem_reg);
        if (cmd.out_load)
        begin
            res_page   <= quo_reg;
            res_status <= op_reg ? ST_REFILL : (hit_reg ? ST_HIT : ST_MISS);
            res_phys   <= (op_reg || hit_reg) ? prod_reg : 32'd0;
        end
    end

    // Entry payload writes
    always_ff @(posedge clk)
    begin
        if (cmd.scan_step && !op_reg && match)
            euse_reg[cur] <= use_cnt_reg;
        if (cmd.write_ent)
        begin
            epid_reg[slot_reg]  <= pid_reg;
            epage_reg[slot_reg] <= quo_reg;
            efrm_reg[slot_reg]  <= frm_reg;
            eload_reg[slot_reg] <= load_cnt_reg;
            euse_reg[slot_reg]  <= use_cnt_reg;
        end
    end

    // Valid bits and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
                valid_reg[i] <= 1'b0;
            load_cnt_reg <= '0;
            use_cnt_reg  <= '0;
        end
        else
        begin
            if (cmd.write_ent)
            begin
                valid_reg[slot_reg] <= 1'b1;
                load_cnt_reg <= load_cnt_reg + 32'd1;
                use_cnt_reg  <= use_cnt_reg + 32'd1;
            end
            if (cmd.mul && !op_reg && hit_reg)
                use_cnt_reg <= use_cnt_reg + 32'd1;
        end
    end
endmodule

/* design/tlb_translate_fifo_lru_unit.sv */
// Top level of the TLB translate unit: ports, output register, and the
// controller and datapath instances. Depends on tlbf_pkg, tlbf_ctrl, tlbf_dp.
//
// Usage: items enter on in_valid/in_ready (opcode, pid, logical_address,
// frame); one result per item leaves on out_valid/out_ready (status,
// physical_address, page_number). Registers are written on cfg_valid/
// cfg_ready with cfg_index 0 page size, 1 entries in use, 2 replace mode;
// the user must write them only while the unit is idle; the unit itself
// does not enforce this. One item at a time: bit-serial division, the tag
// scan over the entries in use (up to ENTRIES), one entry per cycle, a
// refill write for refills with entries in use, the multiply and the
// hand-off. The divider and the entry scan take most of the time per item.
// Reset empties every entry, clears both stamp counters and loads page
// size 64, 32 entries, FIFO. A finished result waits in the output
// register while the receiver stalls; the next item is taken as soon as
// the result has moved to the output register.
module tlb_translate_fifo_lru_unit #(
    parameter int ENTRIES = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        opcode,
    input  logic [15:0] pid,
    input  logic [30:0] logical_address,
    input  logic [15:0] frame,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [31:0] physical_address,
    output logic [30:0] page_number,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import tlbf_pkg::*;

    cmd_t  cmd;
    stat_t st;
    logic  out_valid_reg;

    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;

    // Output register flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    tlbf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .out_busy (out_valid_reg && !out_ready),
        .st       (st),
        .cmd      (cmd)
    );

    tlbf_dp #(.ENTRIES(ENTRIES)) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .st              (st),
        .cfg_valid       (cfg_valid),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .opcode          (opcode),
        .pid             (pid),
        .logical_address (logical_address),
        .frame           (frame),
        .res_status      (status),
        .res_phys        (physical_address),
        .res_page        (page_number)
    );
endmodule
